[rtl/core/linear_discriminant_classify_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the linear discriminant classifier
// Concurrent checks clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_DISCRIMINANT_CLASSIFY_UNIT_DEFINES_SVH
`define LINEAR_DISCRIMINANT_CLASSIFY_UNIT_DEFINES_SVH

// Same-cycle implication
`define LDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/ldc_pkg.sv]
// ----------------------------------------------------------------------------
// ldc_pkg
// Constants, register codes and the logistic table builder for the
// linear discriminant classifier.
// ----------------------------------------------------------------------------
package ldc_pkg;

    // Default sizes
    localparam int MAX_FEATURES_DEF    = 64;
    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int SIGMOID_ENTRIES_DEF = 256;

    // Fixed field widths
    localparam int ACC_W       = 48;
    localparam int LABEL_W     = 8;
    localparam int PROB_W      = 16;
    localparam int COUNT_W     = 7;
    localparam int WIDX_W      = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    // Feature counter saturates here
    localparam logic [COUNT_W-1:0] SEEN_CAP = 7'd127;

    // Item opcodes
    localparam logic OP_WEIGHT  = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BIAS          = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLASS_FIRST   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLASS_SECOND  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEATURE_COUNT = 3'd3;

    // Register reset values
    localparam logic [LABEL_W-1:0] CLASS_FIRST_RST   = 8'd0;
    localparam logic [LABEL_W-1:0] CLASS_SECOND_RST  = 8'd1;
    localparam logic [COUNT_W-1:0] FEATURE_COUNT_RST = 7'd64;

    // Shift-subtract unsigned divide, evaluated at elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        int          b;
        q = '0;
        r = '0;
        for (b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-f) in Q30 for f in Q20, truncated Taylor series
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
        logic [63:0] term;
        logic [63:0] sum;
        int          k;
        term = 64'd1 << 30;
        sum  = 64'd1 << 30;
        for (k = 1; k <= 24; k++) begin
            term = udiv64((term * f) >> 20, 64'(k));
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Logistic value of the midpoint of bin idx out of n bins over [-8,8)
    function automatic logic [PROB_W-1:0] sig_entry(input int idx, input int n);
        longint      num;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] e;
        logic [63:0] e1;
        logic [63:0] d;
        logic [63:0] p;
        logic [63:0] nint;
        logic [16:0] diff;
        int          j;
        num  = (longint'(2 * idx + 1) - longint'(n)) * 64'sd8388608;
        mag  = (num < 0) ? 64'(-num) : 64'(num);
        q    = udiv64(mag, 64'(n));
        nint = q >> 20;
        e1   = exp_neg_q30(64'd1 << 20);
        e    = exp_neg_q30(q & ((64'd1 << 20) - 64'd1));
        for (j = 0; j < 8; j++) begin
            if (64'(j) < nint) begin
                e = (e * e1) >> 30;
            end
        end
        d = (64'd1 << 30) + e;
        p = udiv64((64'd1 << 46) + (d >> 1), d);
        if (num >= 0 || q == 64'd0) begin
            return (p > 64'd65535) ? 16'hFFFF : p[15:0];
        end
        diff = 17'd65536 - p[16:0];
        return diff[15:0];
    endfunction

endpackage

[rtl/core/linear_discriminant_classify_unit.sv]
// Linear discriminant classifier. Weight words load the table; feature words
// stream in at one word per cycle while o_ready is high, with no gap between
// vectors. Each feature is multiplied by its weight and summed in a 48-bit
// saturating accumulator; the word marked last adds the bias and produces one
// result word through registered table read, multiply, accumulate, bias add,
// bin select and logistic lookup steps. Sustained rate is one word per cycle
// unless the result side stalls, set by the registered accumulator feedback.
// The logistic table is a constant built at elaboration, so no load or
// clearing pass follows reset. Weight entries never written read as unknown.
`include "linear_discriminant_classify_unit_defines.svh"

// ----------------------------------------------------------------------------
// linear_discriminant_classify_unit
// Streaming two-class linear discriminant with logistic probability output.
// ----------------------------------------------------------------------------
module linear_discriminant_classify_unit #(
    parameter int MAX_FEATURES    = ldc_pkg::MAX_FEATURES_DEF,
    parameter int SAMPLE_WIDTH    = ldc_pkg::SAMPLE_WIDTH_DEF,
    parameter int SIGMOID_ENTRIES = ldc_pkg::SIGMOID_ENTRIES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ldc_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [ldc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input word channel
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_opcode,
    input  logic [ldc_pkg::WIDX_W-1:0]           i_weight_index,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_sample_value,
    input  logic                                 i_last_feature,
    // result word channel
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [ldc_pkg::LABEL_W-1:0]          o_class_label,
    output logic [ldc_pkg::PROB_W-1:0]           o_probability,
    output logic                                 o_size_error
);

    localparam int ACC_W = ldc_pkg::ACC_W;
    localparam int IW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int PW    = 2 * SAMPLE_WIDTH;
    localparam int SUMW  = ((PW > ACC_W) ? PW : ACC_W) + 1;
    localparam int BW    = $clog2(SIGMOID_ENTRIES);
    localparam int NW    = $clog2(SIGMOID_ENTRIES + 1);
    localparam int MW    = 24 + NW;

    // Saturate a wide sum to the signed accumulator range
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUMW-1:0] v);
        logic [SUMW-ACC_W:0] hi;
        hi = v[SUMW-1:ACC_W-1];
        if ((&hi) || !(|hi)) begin
            return v[ACC_W-1:0];
        end
        if (v[SUMW-1]) begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end
        return {1'b0, {(ACC_W-1){1'b1}}};
    endfunction

    // Logistic table, one constant per bin
    logic [ldc_pkg::PROB_W-1:0] w_sig_lut [SIGMOID_ENTRIES];
    for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_lut
        localparam logic [ldc_pkg::PROB_W-1:0] LUT_VAL =
            ldc_pkg::sig_entry(g, SIGMOID_ENTRIES);
        assign w_sig_lut[g] = LUT_VAL;
    end

    // Configuration registers
    logic signed [ACC_W-1:0]            r_bias;
    logic [ldc_pkg::LABEL_W-1:0]        r_class_first;
    logic [ldc_pkg::LABEL_W-1:0]        r_class_second;
    logic [ldc_pkg::COUNT_W-1:0]        r_feature_count;

    // Vector state
    logic [ldc_pkg::COUNT_W-1:0]        r_seen;
    logic signed [ACC_W-1:0]            r_acc;
    logic signed [SAMPLE_WIDTH-1:0]     r_weight_mem [MAX_FEATURES];

    // Pipeline registers
    logic                               r_s1_valid;
    logic signed [SAMPLE_WIDTH-1:0]     r_s1_weight;
    logic signed [SAMPLE_WIDTH-1:0]     r_s1_sample;
    logic                               r_s1_wok;
    logic                               r_s1_last;
    logic                               r_s1_err;

    logic                               r_s2_valid;
    logic signed [PW-1:0]               r_s2_prod;
    logic                               r_s2_last;
    logic                               r_s2_err;

    logic                               r_s3_valid;
    logic signed [ACC_W-1:0]            r_s3_sum;
    logic                               r_s3_err;

    logic                               r_s4_valid;
    logic signed [ACC_W-1:0]            r_s4_disc;
    logic                               r_s4_err;

    logic                               r_s5_valid;
    logic [BW-1:0]                      r_s5_bin;
    logic                               r_s5_neg;
    logic                               r_s5_err;

    logic                               r_out_valid;
    logic [ldc_pkg::LABEL_W-1:0]        r_out_label;
    logic [ldc_pkg::PROB_W-1:0]         r_out_prob;
    logic                               r_out_err;

    // Combinational values
    logic                               w_rdy_out, w_rdy5, w_rdy4, w_rdy3, w_rdy2, w_rdy1;
    logic                               w_in_acc;
    logic                               w_feat_acc;
    logic [ldc_pkg::COUNT_W-1:0]        n_count;
    logic                               n_err;
    logic [IW-1:0]                      w_rd_idx;
    logic [IW-1:0]                      w_wr_idx;
    logic                               w_wr_ok;
    logic                               w_rd_ok;
    logic signed [PW-1:0]               n_prod;
    logic signed [ACC_W-1:0]            n_sum;
    logic signed [ACC_W-1:0]            n_disc;
    logic [23:0]                        w_offs;
    logic [MW-1:0]                      w_bin_mul;
    logic [BW-1:0]                      n_bin;

    // Ready chain: a stage takes a word when it is empty or drains
    assign w_rdy_out = !r_out_valid || i_ready;
    assign w_rdy5    = !r_s5_valid  || w_rdy_out;
    assign w_rdy4    = !r_s4_valid  || w_rdy5;
    assign w_rdy3    = !r_s3_valid  || w_rdy4;
    assign w_rdy2    = !r_s2_valid  || w_rdy3;
    assign w_rdy1    = !r_s1_valid  || w_rdy2;

    assign o_ready     = w_rdy1;
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && w_rdy1;
    assign w_feat_acc  = w_in_acc && (i_opcode == ldc_pkg::OP_FEATURE);

    // Count, table addresses and size check
    always_comb begin
        n_count  = (r_seen < ldc_pkg::SEEN_CAP) ? r_seen + 7'd1 : ldc_pkg::SEEN_CAP;
        n_err    = (n_count != r_feature_count) || (int'(n_count) > MAX_FEATURES);
        w_rd_idx = IW'(r_seen);
        w_wr_idx = IW'(i_weight_index);
        w_rd_ok  = int'(r_seen) < MAX_FEATURES;
        w_wr_ok  = int'(i_weight_index) < MAX_FEATURES;
    end

    // Multiply, accumulate, bias and bin select
    always_comb begin
        n_prod    = r_s1_wok ? PW'(r_s1_weight * r_s1_sample) : '0;
        n_sum     = sat_acc(SUMW'(r_acc) + SUMW'(r_s2_prod));
        n_disc    = sat_acc(SUMW'(r_s3_sum) + SUMW'(r_bias));
        if ((&r_s4_disc[ACC_W-1:23]) || !(|r_s4_disc[ACC_W-1:23])) begin
            w_offs = {~r_s4_disc[23], r_s4_disc[22:0]};
        end else if (r_s4_disc[ACC_W-1]) begin
            w_offs = 24'h000000;
        end else begin
            w_offs = 24'hFFFFFF;
        end
        w_bin_mul = MW'(w_offs) * MW'(SIGMOID_ENTRIES);
        n_bin     = BW'(w_bin_mul[MW-1:24]);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias          <= '0;
            r_class_first   <= ldc_pkg::CLASS_FIRST_RST;
            r_class_second  <= ldc_pkg::CLASS_SECOND_RST;
            r_feature_count <= ldc_pkg::FEATURE_COUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ldc_pkg::CFG_BIAS:          r_bias          <= i_cfg_data;
                ldc_pkg::CFG_CLASS_FIRST:   r_class_first   <= i_cfg_data[ldc_pkg::LABEL_W-1:0];
                ldc_pkg::CFG_CLASS_SECOND:  r_class_second  <= i_cfg_data[ldc_pkg::LABEL_W-1:0];
                ldc_pkg::CFG_FEATURE_COUNT: r_feature_count <= i_cfg_data[ldc_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Weight table: write on weight words, registered read whenever stage 1 takes a word
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_opcode == ldc_pkg::OP_WEIGHT) && w_wr_ok) begin
            r_weight_mem[w_wr_idx] <= i_sample_value;
        end
        if (w_rdy1) begin
            r_s1_weight <= r_weight_mem[w_rd_idx];
        end
    end

    // Feature counter: advance per feature, clear on last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (w_feat_acc) begin
            r_seen <= i_last_feature ? '0 : n_count;
        end
    end

    // Stage 1: hold sample and flags beside the table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_rdy1) begin
            r_s1_valid <= w_feat_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_sample <= i_sample_value;
            r_s1_wok    <= w_rd_ok;
            r_s1_last   <= i_last_feature;
            r_s1_err    <= n_err;
        end
    end

    // Stage 2: product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_rdy2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_prod <= n_prod;
            r_s2_last <= r_s1_last;
            r_s2_err  <= r_s1_err;
        end
    end

    // Stage 3: accumulate; only last words go on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_s3_valid <= 1'b0;
        end else if (w_rdy3) begin
            r_s3_valid <= r_s2_valid && r_s2_last;
            if (r_s2_valid) begin
                r_acc <= r_s2_last ? '0 : n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3_sum <= n_sum;
            r_s3_err <= r_s2_err;
        end
    end

    // Stage 4: add bias
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_rdy4) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_s4_disc <= n_disc;
            r_s4_err  <= r_s3_err;
        end
    end

    // Stage 5: clamp and pick the bin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (w_rdy5) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_s5_bin <= n_bin;
            r_s5_neg <= r_s4_disc[ACC_W-1];
            r_s5_err <= r_s4_err;
        end
    end

    // Output register: label, probability, error flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rdy_out) begin
            r_out_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out) begin
            r_out_err   <= r_s5_err;
            r_out_prob  <= r_s5_err ? '0 : w_sig_lut[r_s5_bin];
            r_out_label <= r_s5_err ? '0 : (r_s5_neg ? r_class_second : r_class_first);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_class_label = r_out_label;
    assign o_probability = r_out_prob;
    assign o_size_error  = r_out_err;

    // Checks
    `LDC_ASSERT_NOW(a_err_fields_zero, o_valid && o_size_error, (o_class_label == '0) && (o_probability == '0), "error result carries nonzero label or probability")
    `LDC_ASSERT_NOW(a_stall_from_output, !o_ready, r_out_valid && !i_ready, "input stalled while output side can drain")
    `LDC_ASSERT_NEXT(a_acc_clear_on_last, r_s2_valid && r_s2_last && w_rdy3, r_acc == '0, "accumulator not cleared after last feature")
    `LDC_ASSERT_NEXT(a_seen_clear_on_last, w_feat_acc && i_last_feature, r_seen == '0, "feature counter not cleared after last feature")

endmodule

[tb/tb_linear_discriminant_classify_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear discriminant classifier testbench
// Loads the weight table, sends short directed vectors that hit the clamp
// ends, saturation and size errors, then runs random vectors over several
// register settings with sender gaps, receiver stalls and one long output
// hold-off. A cycle-free model of the classifier predicts every result word.
// ----------------------------------------------------------------------------
module tb_linear_discriminant_classify_unit;

    localparam int     SETTLE_CYCLES = 16;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     RING_DEPTH    = 64;
    localparam int     WIDX_W        = ldc_pkg::WIDX_W;
    localparam longint BIAS_MAX      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint BIAS_MIN      = -BIAS_MAX - 1;

    typedef struct packed {
        logic [ldc_pkg::LABEL_W-1:0] label;
        logic [ldc_pkg::PROB_W-1:0]  prob;
        logic                        size_err;
    } t_verdict;

    // Predicts classifier verdicts and matches them against the result words
    class t_verdict_book;
        longint                      weights [ldc_pkg::MAX_FEATURES_DEF];
        longint                      acc;
        int                          seen;
        longint                      bias;
        logic [ldc_pkg::LABEL_W-1:0] first_label;
        logic [ldc_pkg::LABEL_W-1:0] second_label;
        int                          want_count;
        logic [ldc_pkg::PROB_W-1:0]  logistic [ldc_pkg::SIGMOID_ENTRIES_DEF];
        t_verdict                    ring [RING_DEPTH];
        int                          head;
        int                          tail;
        int                          faults;
        int                          results;
        int                          size_errors;

        function new();
            foreach (weights[i]) weights[i] = 0;
            acc          = 0;
            seen         = 0;
            bias         = 0;
            first_label  = ldc_pkg::CLASS_FIRST_RST;
            second_label = ldc_pkg::CLASS_SECOND_RST;
            want_count   = ldc_pkg::FEATURE_COUNT_RST;
            head         = 0;
            tail         = 0;
            faults       = 0;
            results      = 0;
            size_errors  = 0;
            build_logistic();
        endfunction

        // exp(-f), Q20 in, Q30 out, truncated Taylor terms
        function logic [63:0] exp_neg(logic [63:0] f);
            logic [63:0] term;
            logic [63:0] sum;
            int          k;
            term = 64'd1 << 30;
            sum  = 64'd1 << 30;
            for (k = 1; k <= 24; k++) begin
                term = ((term * f) >> 20) / 64'(k);
                if (k % 2 == 1) sum = sum - term;
                else sum = sum + term;
            end
            return sum;
        endfunction

        // Logistic value at the midpoint of each bin over [-8,8)
        function void build_logistic();
            logic [63:0] e1;
            logic [63:0] e;
            logic [63:0] d;
            logic [63:0] p;
            logic [63:0] mag;
            longint      mid;
            int          n;
            e1 = exp_neg(64'd1 << 20);
            for (int i = 0; i < ldc_pkg::SIGMOID_ENTRIES_DEF; i++) begin
                mid = (longint'(2 * i + 1 - ldc_pkg::SIGMOID_ENTRIES_DEF) * 64'sd8388608)
                      / ldc_pkg::SIGMOID_ENTRIES_DEF;
                mag = 64'(mid < 0 ? -mid : mid);
                n   = int'(mag >> 20);
                e   = exp_neg(mag & ((64'd1 << 20) - 64'd1));
                repeat (n) e = (e * e1) >> 30;
                d = (64'd1 << 30) + e;
                p = ((64'd1 << 46) + d / 2) / d;
                if (mid >= 0) logistic[i] = (p > 64'd65535) ? 16'hFFFF : p[15:0];
                else logistic[i] = 16'(64'd65536 - p);
            end
        endfunction

        function longint clip48(longint v);
            if (v > BIAS_MAX) return BIAS_MAX;
            if (v < BIAS_MIN) return BIAS_MIN;
            return v;
        endfunction

        function void set_reg(logic [ldc_pkg::CFG_INDEX_W-1:0] idx,
                              logic [ldc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ldc_pkg::CFG_BIAS:          bias = longint'($signed(data[47:0]));
                ldc_pkg::CFG_CLASS_FIRST:   first_label = data[ldc_pkg::LABEL_W-1:0];
                ldc_pkg::CFG_CLASS_SECOND:  second_label = data[ldc_pkg::LABEL_W-1:0];
                ldc_pkg::CFG_FEATURE_COUNT: want_count = int'(data[ldc_pkg::COUNT_W-1:0]);
                default: ;
            endcase
        endfunction

        // Apply one accepted input word and queue the verdict it yields
        function void take_word(logic op, logic [WIDX_W-1:0] idx,
                                logic signed [15:0] val, logic last);
            longint   prod;
            longint   a;
            longint   c;
            int       cnt;
            int       bin;
            t_verdict v;
            if (op == ldc_pkg::OP_WEIGHT) begin
                weights[idx] = longint'(val);
                return;
            end
            prod = (seen < ldc_pkg::MAX_FEATURES_DEF) ? weights[seen] * longint'(val) : 0;
            a    = clip48(acc + prod);
            cnt  = (seen < int'(ldc_pkg::SEEN_CAP)) ? seen + 1 : int'(ldc_pkg::SEEN_CAP);
            if (!last) begin
                acc  = a;
                seen = cnt;
                return;
            end
            acc  = 0;
            seen = 0;
            if (cnt != want_count || cnt > ldc_pkg::MAX_FEATURES_DEF) begin
                v = '{label: '0, prob: '0, size_err: 1'b1};
            end else begin
                a = clip48(a + bias);
                c = a;
                if (c < -64'sd8388608) c = -64'sd8388608;
                if (c > 64'sd8388607) c = 64'sd8388607;
                bin = int'(((c + 64'sd8388608) * ldc_pkg::SIGMOID_ENTRIES_DEF) >>> 24);
                v.label    = (a >= 0) ? first_label : second_label;
                v.prob     = logistic[bin];
                v.size_err = 1'b0;
            end
            ring[tail % RING_DEPTH] = v;
            tail++;
        endfunction

        function void match_result(logic [ldc_pkg::LABEL_W-1:0] label,
                                   logic [ldc_pkg::PROB_W-1:0] prob, logic size_err);
            t_verdict v;
            results++;
            if (size_err) size_errors++;
            if (tail == head) begin
                faults++;
                $display("%0t unexpected result word: expected none, actual %0d/%0d/%0d",
                         $time, label, prob, size_err);
                return;
            end
            v = ring[head % RING_DEPTH];
            head++;
            if (label !== v.label) begin
                faults++;
                $display("%0t class_label: expected %0d, actual %0d", $time, v.label, label);
            end
            if (prob !== v.prob) begin
                faults++;
                $display("%0t probability: expected %0d, actual %0d", $time, v.prob, prob);
            end
            if (size_err !== v.size_err) begin
                faults++;
                $display("%0t size_error: expected %0d, actual %0d", $time, v.size_err,
                         size_err);
            end
        endfunction

        function int pending();
            return tail - head;
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [ldc_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [ldc_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic                            i_opcode = 1'b0;
    logic [WIDX_W-1:0]               i_weight_index = '0;
    logic signed [15:0]              i_sample_value = '0;
    logic                            i_last_feature = 1'b0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [ldc_pkg::LABEL_W-1:0]     o_class_label;
    logic [ldc_pkg::PROB_W-1:0]      o_probability;
    logic                            o_size_error;

    t_verdict_book book;
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int hold_reqs    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int words_sent   = 0;
    int reg_writes   = 0;
    int settings     = 0;

    linear_discriminant_classify_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_weight_index (i_weight_index),
        .i_sample_value (i_sample_value),
        .i_last_feature (i_last_feature),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_class_label  (o_class_label),
        .o_probability  (o_probability),
        .o_size_error   (o_size_error)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Drive result ready: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            book.match_result(o_class_label, o_probability, o_size_error);
        end
    end

    initial begin
        #1_000_000;
        $display("linear_discriminant_classify_unit: mismatch");
        $finish;
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(3))
            0: return 16'($signed($urandom_range(512)) - 256);
            1: case ($urandom_range(3))
                   0: return 16'h8000;
                   1: return 16'h7FFF;
                   2: return 16'h0000;
                   default: return 16'hFFFF;
               endcase
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic longint pick_bias();
        case ($urandom_range(3))
            0: return 0;
            1: return longint'($urandom_range(1 << 26)) - (1 << 25);
            2: return longint'($signed({$urandom(), $urandom()} >> 16) >>> 0)
                      - (longint'($urandom_range(1)) << 47);
            default: return $urandom_range(1) ? BIAS_MAX : BIAS_MIN;
        endcase
    endfunction

    // Offer one word and hold it until accepted
    task automatic send_word(input logic op, input logic [WIDX_W-1:0] idx,
                             input logic [15:0] val, input logic last);
        while (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_weight_index <= idx;
        i_sample_value <= val;
        i_last_feature <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        book.take_word(op, idx, val, last);
        words_sent++;
    endtask

    // Drop valid, wait for all results, then let the pipeline empty
    task automatic settle();
        i_valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input longint bias, input int first, input int second,
                                input int count);
        logic [ldc_pkg::CFG_INDEX_W-1:0] codes [4];
        logic [ldc_pkg::CFG_DATA_W-1:0]  vals [4];
        codes = '{ldc_pkg::CFG_BIAS, ldc_pkg::CFG_CLASS_FIRST, ldc_pkg::CFG_CLASS_SECOND,
                  ldc_pkg::CFG_FEATURE_COUNT};
        vals  = '{48'(bias), 48'(first), 48'(second), 48'(count)};
        settle();
        for (int r = 0; r < 4; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= codes[r];
            i_cfg_data  <= vals[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            book.set_reg(codes[r], vals[r]);
            reg_writes++;
        end
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    // One feature vector, with weight words sprinkled in
    task automatic send_vector(input int len, input int weight_pct);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < weight_pct) begin
                send_word(ldc_pkg::OP_WEIGHT, WIDX_W'($urandom_range(63)), pick_sample(),
                          1'($urandom_range(1)));
            end
            send_word(ldc_pkg::OP_FEATURE, WIDX_W'($urandom_range(63)), pick_sample(),
                      k == len - 1);
        end
    endtask

    task automatic run_phase(input int count, input int tx, input int rx,
                             input int budget, input bit squeeze, input bit overflow);
        int start;
        int len;
        int pick;
        program_regs(pick_bias(), $urandom_range(255), $urandom_range(255), count);
        tx_gap_pct   = tx;
        rx_stall_pct = rx;
        if (squeeze) hold_reqs <= hold_reqs + 1;
        // too many features: counter saturates, result is a size error
        if (overflow) send_vector(130, 0);
        start = words_sent;
        while (words_sent - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 80) len = count;
            else if (pick < 95) len = $urandom_range(count + 2, 1);
            else len = $urandom_range(3, 1);
            send_vector(len, 8);
        end
    endtask

    initial begin
        book = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole weight table before any feature reads it
        for (int i = 0; i < ldc_pkg::MAX_FEATURES_DEF; i++) begin
            send_word(ldc_pkg::OP_WEIGHT, WIDX_W'(i), pick_sample(), 1'($urandom_range(1)));
        end

        // Single-feature vectors at the extremes and the centre of the clamp range
        program_regs(0, 8'hA5, 8'h5A, 1);
        send_word(ldc_pkg::OP_WEIGHT, 6'd0, 16'h8000, 1'b1);
        send_word(ldc_pkg::OP_FEATURE, 6'd63, 16'h8000, 1'b1);
        send_word(ldc_pkg::OP_FEATURE, 6'd0, 16'h7FFF, 1'b1);
        send_word(ldc_pkg::OP_FEATURE, 6'd21, 16'h0000, 1'b1);
        send_word(ldc_pkg::OP_WEIGHT, 6'd0, 16'h0001, 1'b0);
        send_word(ldc_pkg::OP_FEATURE, 6'd42, 16'h0001, 1'b1);
        send_word(ldc_pkg::OP_FEATURE, 6'd0, 16'hFFFF, 1'b1);
        // Vector one longer than configured
        send_word(ldc_pkg::OP_FEATURE, 6'd0, 16'h0100, 1'b0);
        send_word(ldc_pkg::OP_FEATURE, 6'd0, 16'h0100, 1'b1);
        send_word(ldc_pkg::OP_WEIGHT, 6'd63, 16'h7FFF, 1'b1);

        // Saturate the sum against each bias extreme
        program_regs(BIAS_MAX, 8'hFF, 8'h00, 1);
        send_word(ldc_pkg::OP_FEATURE, 6'd0, 16'h7FFF, 1'b1);
        send_word(ldc_pkg::OP_FEATURE, 6'd0, 16'h0000, 1'b1);
        program_regs(BIAS_MIN, 8'h00, 8'hFF, 1);
        send_word(ldc_pkg::OP_FEATURE, 6'd0, 16'h8000, 1'b1);

        // A zero feature count always errs
        program_regs(0, 8'h11, 8'h22, 0);
        send_word(ldc_pkg::OP_FEATURE, 6'd0, 16'h1234, 1'b1);

        run_phase(64, 0, 0, 120, 1'b0, 1'b1);
        run_phase(1, 70, 0, 100, 1'b0, 1'b0);
        run_phase(8, 0, 70, 100, 1'b0, 1'b0);
        run_phase(1, 0, 0, 100, 1'b1, 1'b0);
        run_phase(64, 24, 24, 100, 1'b0, 1'b0);
        run_phase(3, 0, 0, 90, 1'b0, 1'b0);
        run_phase($urandom_range(64, 1), 70, 0, 80, 1'b0, 1'b0);
        run_phase(5, 24, 24, 80, 1'b0, 1'b0);

        settle();
        $display("Covered %0d input words and %0d result words (%0d size errors)",
                 words_sent, book.results, book.size_errors);
        $display("over %0d register settings (%0d writes), with gaps, stalls and a long hold-off",
                 settings, reg_writes);
        if (book.faults == 0) begin
            $display("linear_discriminant_classify_unit: match");
        end else begin
            $display("linear_discriminant_classify_unit: mismatch");
        end
        $finish;
    end

endmodule
